// File: rtl/core/prsu_pkg.sv
// ----------------------------------------------------------------------------
// prsu_pkg: shared definitions for the PNG row sample unpacker
// Register indexes, mode, depth, opcode and channel codes, and the sample descriptor passed
// from the sampler to the emitter.
// ----------------------------------------------------------------------------
package prsu_pkg;

	localparam int MAX_WIDTH_DEF     = 8192;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int ROW_LIMIT         = 8192;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

	localparam logic [2:0] MODE_GREY       = 3'd0;
	localparam logic [2:0] MODE_GREY_ALPHA = 3'd1;
	localparam logic [2:0] MODE_TRUE       = 3'd2;
	localparam logic [2:0] MODE_TRUE_ALPHA = 3'd3;
	localparam logic [2:0] MODE_INDEXED    = 3'd4;

	localparam logic [2:0] DEPTH_1  = 3'd0;
	localparam logic [2:0] DEPTH_2  = 3'd1;
	localparam logic [2:0] DEPTH_4  = 3'd2;
	localparam logic [2:0] DEPTH_8  = 3'd3;
	localparam logic [2:0] DEPTH_16 = 3'd4;

	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  channel;
		logic [12:0] column;
		logic [12:0] row;
		logic        eor;
		logic        eoi;
		logic        last;
		logic        indexed;
		logic        oob;
	} dsc_t;

endpackage

// File: rtl/core/png_row_sample_unpacker.sv
// ----------------------------------------------------------------------------
// png_row_sample_unpacker: PNG scanline sample unpacker
// Usage:
//   The in channel carries palette loads (opcode 0) and unfiltered scanline
//   bytes (opcode 1). The out channel carries one color component per beat
//   with its channel, column, row and end-of-row / end-of-image / last-of-run
//   flags. The cfg channel writes color_mode, depth_code, image_width and
//   image_height by index; cfg_ready is always high, and writes must be
//   made only while the block is idle; the block does not enforce this.
//   Path: a byte moves from the input register through the sample stage
//   into the output register. While nothing downstream stalls, the
//   sampler takes one sample per cycle and the emitter one component per
//   cycle; an indexed sample yields three components, and the input
//   register takes a new byte as the last sample of the current one is taken.
//   Reset clears the position counters and loads the register defaults
//   (grey, 8 bits, 1x1); palette contents stay undefined until loaded.
//   When the receiver stalls, the output register holds its beat, the
//   sample stage and input register fill, then in_ready drops.
// ----------------------------------------------------------------------------
module png_row_sample_unpacker #(
	parameter int MAX_WIDTH = prsu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = prsu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prsu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [7:0]                         data_byte,
	input  logic [7:0]                         entry_index,
	input  logic [7:0]                         entry_red,
	input  logic [7:0]                         entry_green,
	input  logic [7:0]                         entry_blue,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [15:0]                        sample_value,
	output logic [1:0]                         channel,
	output logic [12:0]                        column,
	output logic [12:0]                        row_number,
	output logic                               end_of_row,
	output logic                               end_of_image,
	output logic                               last_of_run
);

	import prsu_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [2:0]    color_mode_q;
	logic [2:0]    depth_code_q;
	logic [13:0]   image_width_q;
	logic [13:0]   image_height_q;

	logic          dsc_valid;
	logic          dsc_ready;
	dsc_t          dsc;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [23:0]   ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [23:0]   ram_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= MODE_GREY;
			depth_code_q   <= DEPTH_8;
			image_width_q  <= 14'd1;
			image_height_q <= 14'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLOR_MODE:   color_mode_q   <= cfg_data[2:0];
				CFG_DEPTH_CODE:   depth_code_q   <= cfg_data[2:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          image_height_q <= image_height_q;
			endcase
		end
	end

	prsu_sampler #(
		.MAX_WIDTH     (MAX_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_sampler (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.entry_index  (entry_index),
		.entry_red    (entry_red),
		.entry_green  (entry_green),
		.entry_blue   (entry_blue),
		.color_mode   (color_mode_q),
		.depth_code   (depth_code_q),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.dsc_ready    (dsc_ready),
		.dsc_valid    (dsc_valid),
		.dsc          (dsc),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr)
	);

	prsu_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	prsu_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.dsc_valid    (dsc_valid),
		.dsc_ready    (dsc_ready),
		.dsc          (dsc),
		.ram_rd_data  (ram_rd_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value),
		.channel      (channel),
		.column       (column),
		.row_number   (row_number),
		.end_of_row   (end_of_row),
		.end_of_image (end_of_image),
		.last_of_run  (last_of_run)
	);

endmodule

// File: rtl/core/prsu_ram.sv
// ----------------------------------------------------------------------------
// prsu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prsu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/prsu_sampler.sv
// ----------------------------------------------------------------------------
// prsu_sampler: input register and per-sample position tracking
// Holds one input beat, splits data bytes into samples one per cycle when not
// stalled, tracks channel, column, row, and issues palette writes and reads.
// ----------------------------------------------------------------------------
module prsu_sampler #(
	parameter int MAX_WIDTH = prsu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = prsu_pkg::PALETTE_DEPTH_DEF,
	localparam int AW = $clog2(PALETTE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           entry_index,
	input  logic [7:0]           entry_red,
	input  logic [7:0]           entry_green,
	input  logic [7:0]           entry_blue,
	input  logic [2:0]           color_mode,
	input  logic [2:0]           depth_code,
	input  logic [13:0]          image_width,
	input  logic [13:0]          image_height,
	input  logic                 dsc_ready,
	output logic                 dsc_valid,
	output prsu_pkg::dsc_t       dsc,
	output logic                 ram_wr_en,
	output logic [AW-1:0]        ram_wr_addr,
	output logic [23:0]          ram_wr_data,
	output logic                 ram_rd_en,
	output logic [AW-1:0]        ram_rd_addr
);

	import prsu_pkg::*;

	localparam int WEFF  = (MAX_WIDTH < 16383) ? MAX_WIDTH : 16383;
	localparam int COL_W = (WEFF > 1) ? $clog2(WEFF) : 1;
	localparam logic [16:0] PD17 = 17'(PALETTE_DEPTH);
	localparam logic [8:0]  PD9  = 9'(PALETTE_DEPTH);

	logic             in_valid_s1;
	logic             in_op_s1;
	logic [7:0]       in_byte_s1;
	logic [7:0]       in_idx_s1;
	logic [23:0]      in_rgb_s1;

	logic [2:0]       smp_q;
	logic [7:0]       hold_q;
	logic             phase_q;
	logic [1:0]       chan_q;
	logic [COL_W-1:0] col_q;
	logic [12:0]      row_q;

	logic [2:0]       nch;
	logic [1:0]       used;
	logic             has_alpha;
	logic             indexed;
	logic             is16;
	logic [2:0]       k_last;
	logic [2:0]       shamt;
	logic [7:0]       shifted;
	logic [15:0]      sample;

	logic [13:0]      w_eff;
	logic [13:0]      w_m1_full;
	logic [COL_W-1:0] w_m1;
	logic [13:0]      h_eff;
	logic [13:0]      h_m1_full;
	logic [12:0]      h_m1;
	logic [1:0]       nch_m1;
	logic [1:0]       ch_c;
	logic [COL_W-1:0] col_c;
	logic [12:0]      row_c;
	logic [15:0]      col_wide;

	logic             pix_end;
	logic             row_close;
	logic [1:0]       ch_n;
	logic [COL_W-1:0] col_n;
	logic [12:0]      row_n;

	logic             is_data;
	logic             hi_byte;
	logic             take;
	logic             byte_last;
	logic             done;
	logic             fire;
	logic             emit;
	logic             eor;
	logic             eoi;
	logic             last_res;

	always_comb begin
		nch       = 3'd1;
		used      = 2'd1;
		has_alpha = 1'b0;
		indexed   = 1'b0;
		unique case (color_mode)
			MODE_GREY_ALPHA: begin
				nch       = 3'd2;
				has_alpha = 1'b1;
			end
			MODE_TRUE: begin
				nch  = 3'd3;
				used = 2'd3;
			end
			MODE_TRUE_ALPHA: begin
				nch       = 3'd4;
				used      = 2'd3;
				has_alpha = 1'b1;
			end
			MODE_INDEXED: begin
				indexed = 1'b1;
			end
			default: begin
				nch = 3'd1;
			end
		endcase
	end

	always_comb begin
		is16   = 1'b0;
		k_last = 3'd0;
		shamt  = 3'd0;
		unique case (depth_code)
			DEPTH_1: begin
				k_last = 3'd7;
				shamt  = smp_q;
			end
			DEPTH_2: begin
				k_last = 3'd3;
				shamt  = {smp_q[1:0], 1'b0};
			end
			DEPTH_4: begin
				k_last = 3'd1;
				shamt  = {smp_q[0], 2'b00};
			end
			DEPTH_16: begin
				is16 = 1'b1;
			end
			default: begin
				k_last = 3'd0;
			end
		endcase
	end

	assign shifted = in_byte_s1 << shamt;

	always_comb begin
		unique case (depth_code)
			DEPTH_1:  sample = {15'd0, shifted[7]};
			DEPTH_2:  sample = {14'd0, shifted[7:6]};
			DEPTH_4:  sample = {12'd0, shifted[7:4]};
			DEPTH_16: sample = {hold_q, in_byte_s1};
			default:  sample = {8'd0, in_byte_s1};
		endcase
	end

	always_comb begin
		w_eff = (image_width == 14'd0) ? 14'd1 : image_width;
		if (w_eff > 14'(WEFF)) begin
			w_eff = 14'(WEFF);
		end
		w_m1_full = w_eff - 14'd1;
		w_m1      = w_m1_full[COL_W-1:0];

		h_eff = (image_height == 14'd0) ? 14'd1 : image_height;
		if (h_eff > 14'(ROW_LIMIT)) begin
			h_eff = 14'(ROW_LIMIT);
		end
		h_m1_full = h_eff - 14'd1;
		h_m1      = h_m1_full[12:0];

		nch_m1 = 2'(nch - 3'd1);
		ch_c   = ({1'b0, chan_q} >= nch) ? nch_m1 : chan_q;
		col_c  = (col_q > w_m1) ? w_m1 : col_q;
		row_c  = (row_q > h_m1) ? h_m1 : row_q;
	end

	assign col_wide  = 16'(col_c);
	assign pix_end   = (ch_c == nch_m1);
	assign row_close = pix_end && (col_c == w_m1);
	assign ch_n      = pix_end ? 2'd0 : 2'(ch_c + 2'd1);
	assign col_n     = pix_end ? ((col_c == w_m1) ? '0 : COL_W'(col_c + 1'b1)) : col_c;
	assign row_n     = row_close ? ((row_c == h_m1) ? 13'd0 : 13'(row_c + 13'd1)) : row_c;

	assign is_data   = (in_op_s1 == OP_DATA);
	assign hi_byte   = is16 && !phase_q;
	assign take      = is_data && !hi_byte;
	assign byte_last = (smp_q == k_last);
	assign done      = !is_data || hi_byte || byte_last || row_close;
	assign fire      = in_valid_s1 && dsc_ready;
	assign emit      = (ch_c < used);
	assign eor       = (col_c == w_m1) && (ch_c == 2'(used - 2'd1));
	assign eoi       = eor && (row_c == h_m1);
	assign last_res  = done || (has_alpha && (ch_c == 2'(used - 2'd1))
		&& ((3'(smp_q + 3'd1) == k_last) || (col_c == w_m1)));

	assign in_ready  = !in_valid_s1 || (fire && done);
	assign dsc_valid = fire && take && emit;

	assign dsc.value   = sample;
	assign dsc.channel = ch_c;
	assign dsc.column  = col_wide[12:0];
	assign dsc.row     = row_c;
	assign dsc.eor     = eor;
	assign dsc.eoi     = eoi;
	assign dsc.last    = last_res;
	assign dsc.indexed = indexed;
	assign dsc.oob     = ({1'b0, sample} >= PD17);

	assign ram_rd_en   = dsc_valid && indexed;
	assign ram_rd_addr = sample[AW-1:0];
	assign ram_wr_en   = fire && !is_data && ({1'b0, in_idx_s1} < PD9);
	assign ram_wr_addr = in_idx_s1[AW-1:0];
	assign ram_wr_data = in_rgb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			smp_q       <= 3'd0;
			hold_q      <= 8'd0;
			phase_q     <= 1'b0;
			chan_q      <= 2'd0;
			col_q       <= '0;
			row_q       <= 13'd0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (fire) begin
				smp_q <= done ? 3'd0 : 3'(smp_q + 3'd1);
				if (is_data) begin
					if (hi_byte) begin
						hold_q  <= in_byte_s1;
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
					end
				end
				if (take) begin
					chan_q <= ch_n;
					col_q  <= col_n;
					row_q  <= row_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_op_s1   <= opcode;
			in_byte_s1 <= data_byte;
			in_idx_s1  <= entry_index;
			in_rgb_s1  <= {entry_red, entry_green, entry_blue};
		end
	end

endmodule

// File: rtl/core/prsu_emitter.sv
// ----------------------------------------------------------------------------
// prsu_emitter: sample stage and output register
// Turns one sample descriptor into one result, or three palette components
// for indexed samples, and drives the output channel.
// ----------------------------------------------------------------------------
module prsu_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dsc_valid,
	output logic           dsc_ready,
	input  prsu_pkg::dsc_t dsc,
	input  logic [23:0]    ram_rd_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    sample_value,
	output logic [1:0]     channel,
	output logic [12:0]    column,
	output logic [12:0]    row_number,
	output logic           end_of_row,
	output logic           end_of_image,
	output logic           last_of_run
);

	import prsu_pkg::*;

	logic        valid_s2;
	dsc_t        dsc_s2;
	logic [1:0]  comp_q;

	logic        out_valid_q;
	logic [15:0] value_q;
	logic [1:0]  channel_q;
	logic [12:0] column_q;
	logic [12:0] row_q;
	logic        eor_q;
	logic        eoi_q;
	logic        last_q;

	logic        out_free;
	logic        step;
	logic        s2_last;
	logic [7:0]  comp_val;
	logic [15:0] res_value;
	logic [1:0]  res_channel;

	assign out_free  = !out_valid_q || out_ready;
	assign step      = valid_s2 && out_free;
	assign s2_last   = !dsc_s2.indexed || (comp_q == CH_BLUE);
	assign dsc_ready = !valid_s2 || (step && s2_last);

	always_comb begin
		unique case (comp_q)
			CH_RED:   comp_val = ram_rd_data[23:16];
			CH_GREEN: comp_val = ram_rd_data[15:8];
			default:  comp_val = ram_rd_data[7:0];
		endcase
		if (dsc_s2.indexed) begin
			res_value   = dsc_s2.oob ? 16'd0 : {8'd0, comp_val};
			res_channel = comp_q;
		end else begin
			res_value   = dsc_s2.value;
			res_channel = dsc_s2.channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			comp_q      <= CH_RED;
			out_valid_q <= 1'b0;
		end else begin
			if (dsc_ready) begin
				valid_s2 <= dsc_valid;
				comp_q   <= CH_RED;
			end else if (step) begin
				comp_q <= 2'(comp_q + 2'd1);
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dsc_valid && dsc_ready) begin
			dsc_s2 <= dsc;
		end
		if (step) begin
			value_q   <= res_value;
			channel_q <= res_channel;
			column_q  <= dsc_s2.column;
			row_q     <= dsc_s2.row;
			eor_q     <= dsc_s2.eor && s2_last;
			eoi_q     <= dsc_s2.eoi && s2_last;
			last_q    <= dsc_s2.last && s2_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = value_q;
	assign channel      = channel_q;
	assign column       = column_q;
	assign row_number   = row_q;
	assign end_of_row   = eor_q;
	assign end_of_image = eoi_q;
	assign last_of_run  = last_q;

endmodule
